@@ sv/dcd_pkg.sv @@
// ----------------------------------------------------------------------------
// dcd_pkg
// Shared types, constants and small helpers of the day clock with delay slots.
// ----------------------------------------------------------------------------
package dcd_pkg;

	localparam int SEC_W   = 17;   // seconds of day
	localparam int ACC_W   = 18;   // now + delay before the day wrap
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int RAW_W   = 8;
	localparam int REQ_W   = 3;
	localparam int SLOT_IN_W = 4;
	localparam int DEF_DELAY_SLOTS = 16;

	localparam logic [SEC_W-1:0] DAY_SEC      = 17'd86400;
	localparam logic [SEC_W-1:0] DAY_LAST_SEC = 17'd86399;
	localparam logic [SEC_W-1:0] HOUR_SEC     = 17'd3600;
	localparam logic [SEC_W-1:0] MIN_SEC      = 17'd60;
	localparam logic [SLOT_IN_W-1:0] SLOT_MASK = 4'h0F;
	localparam logic [RAW_W-1:0] HOURS_PER_DAY = 8'd24;
	localparam logic [RAW_W-1:0] MINS_PER_HOUR = 8'd60;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK_UP   = 3'd0,
		REQ_TICK_DOWN = 3'd1,
		REQ_PRESET    = 3'd2,
		REQ_SET_HOUR  = 3'd3,
		REQ_SET_MIN   = 3'd4,
		REQ_SET_SEC   = 3'd5,
		REQ_DELAY     = 3'd6
	} req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC,
		S_WRAP,
		S_TEST,
		S_HOUR,
		S_MIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic rd;      // fetch the target of the addressed slot
		logic arm;     // write target and set armed
		logic disarm;  // clear armed
	} slot_cmd_t;

	function automatic logic [SEC_W-1:0] compose(input logic [HOUR_W-1:0] h,
		input logic [MIN_W-1:0] m, input logic [MIN_W-1:0] s);
		logic [SEC_W-1:0] hs;
		logic [SEC_W-1:0] ms;
		hs = SEC_W'(h) * HOUR_SEC;
		ms = SEC_W'(m) * MIN_SEC;
		return hs + ms + SEC_W'(s);
	endfunction

	// tens digit of a value below 60
	function automatic logic [2:0] tens_of(input logic [MIN_W-1:0] v);
		logic [2:0] t;
		if (v >= 6'd50) t = 3'd5;
		else if (v >= 6'd40) t = 3'd4;
		else if (v >= 6'd30) t = 3'd3;
		else if (v >= 6'd20) t = 3'd2;
		else if (v >= 6'd10) t = 3'd1;
		else t = 3'd0;
		return t;
	endfunction

	function automatic logic [3:0] units_of(input logic [MIN_W-1:0] v);
		logic [MIN_W-1:0] tt;
		tt = MIN_W'(tens_of(v)) * 6'd10;
		return 4'(v - tt);
	endfunction

endpackage

@@ sv/dcd_sub.sv @@
// ----------------------------------------------------------------------------
// dcd_sub
// Shared subtract and compare unit: difference and a >= b flag.
// ----------------------------------------------------------------------------
module dcd_sub (
	input  logic [dcd_pkg::ACC_W-1:0] a,
	input  logic [dcd_pkg::ACC_W-1:0] b,
	output logic [dcd_pkg::ACC_W-1:0] diff,
	output logic                      ge
);

	logic [dcd_pkg::ACC_W:0] wide;

	// borrow out of the extended subtract gives the compare
	assign wide = {1'b0, a} - {1'b0, b};
	assign diff = wide[dcd_pkg::ACC_W-1:0];
	assign ge   = ~wide[dcd_pkg::ACC_W];

endmodule

@@ sv/dcd_slots.sv @@
// ----------------------------------------------------------------------------
// dcd_slots
// Delay slot store: target memory with registered read, armed flags.
// ----------------------------------------------------------------------------
module dcd_slots #(
	parameter int DELAY_SLOTS = dcd_pkg::DEF_DELAY_SLOTS,
	parameter int SLOT_W = (DELAY_SLOTS > 1) ? $clog2(DELAY_SLOTS) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dcd_pkg::slot_cmd_t        cmd,
	input  logic [SLOT_W-1:0]         idx,
	input  logic [dcd_pkg::SEC_W-1:0] wr_target,
	output logic                      armed,
	output logic [dcd_pkg::SEC_W-1:0] rd_target
);

	logic [dcd_pkg::SEC_W-1:0] target_mem [DELAY_SLOTS];
	logic [DELAY_SLOTS-1:0]    armed_q;

	assign armed = armed_q[idx];

	always_ff @(posedge clk) begin
		if (cmd.arm) begin
			target_mem[idx] <= wr_target;
		end
		if (cmd.rd) begin
			rd_target <= target_mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
		end else if (cmd.arm) begin
			armed_q[idx] <= 1'b1;
		end else if (cmd.disarm) begin
			armed_q[idx] <= 1'b0;
		end
	end

endmodule

@@ sv/day_clock_with_delay_slots.sv @@
// ----------------------------------------------------------------------------
// day_clock_with_delay_slots
// Time-of-day clock in seconds with one-shot delay slots.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel (kind in s_tuser, operands in s_tdata);
// every request gives exactly one result on the m_ channel: the time after
// the request, its hour/minute/second split, decimal digits and a fired flag.
// One request is in work at a time; s_tready is high only while idle.
// Work per request, from acceptance to m_tvalid:
//   tick, preset, set: the new time is split by repeated subtraction of
//     3600 and then 60 on the shared unit.
//   delay, slot armed: one target read, one compare.
//   delay, slot unarmed: now + length wrapped by one day through up to two
//     subtractions of 86400.
// The result waits in an output register; the next request is taken while
// it waits, but its own result is held back until m_tready drains the first.
// Reset clears the time to 00:00:00, disarms all slots and drops m_tvalid.
// ----------------------------------------------------------------------------
module day_clock_with_delay_slots #(
	parameter int DELAY_SLOTS = dcd_pkg::DEF_DELAY_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// hour_value[7:0], minute_value[15:8], second_value[23:16],
	// delay_slot[27:24], delay_length[44:28], zero pad [47:45]
	input  logic [47:0] s_tdata,
	// req_type[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// day_seconds[16:0], hour_now[21:17], minute_now[27:22], second_now[33:28],
	// hour_tens[35:34], hour_units[39:36], minute_tens[42:40],
	// minute_units[46:43], second_tens[49:47], second_units[53:50],
	// delay_fired[54], zero pad [55]
	output logic [55:0] m_tdata
);

	localparam int SLOT_W = (DELAY_SLOTS > 1) ? $clog2(DELAY_SLOTS) : 1;
	localparam int SEC_W  = dcd_pkg::SEC_W;
	localparam int ACC_W  = dcd_pkg::ACC_W;
	localparam int HOUR_W = dcd_pkg::HOUR_W;
	localparam int MIN_W  = dcd_pkg::MIN_W;
	localparam int RAW_W  = dcd_pkg::RAW_W;
	localparam int SLOT_IN_MSB = dcd_pkg::SLOT_IN_W - 1;

	dcd_pkg::state_t state_q, state_d;

	// latched request
	logic [dcd_pkg::REQ_W-1:0] req_q;
	logic [RAW_W-1:0]          hv_q, mv_q, sv_q;
	logic [SLOT_W-1:0]         slot_q;
	logic                      slot_ok_q;
	logic [SEC_W-1:0]          len_q;

	// time state and its split
	logic [SEC_W-1:0]  sec_q;
	logic [HOUR_W-1:0] hour_q;
	logic [MIN_W-1:0]  min_q, s_q;

	// working registers
	logic [ACC_W-1:0]  acc_q;
	logic [SEC_W-1:0]  new_q;
	logic [HOUR_W-1:0] hcnt_q;
	logic [MIN_W-1:0]  mcnt_q;
	logic              fired_q;

	logic              out_valid_q;
	logic [55:0]       out_data_q;

	logic [ACC_W-1:0]  sub_a, sub_b, sub_diff;
	logic              sub_ge;
	dcd_pkg::slot_cmd_t slot_cmd;
	logic              slot_armed;
	logic [SEC_W-1:0]  slot_target;
	logic              accept, load_out;
	logic [SEC_W-1:0]  new_sec;
	logic [SLOT_IN_MSB:0] slot_in;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == dcd_pkg::S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign slot_in  = s_tdata[27:24] & dcd_pkg::SLOT_MASK;

	dcd_sub u_sub (
		.a    (sub_a),
		.b    (sub_b),
		.diff (sub_diff),
		.ge   (sub_ge)
	);

	dcd_slots #(
		.DELAY_SLOTS (DELAY_SLOTS),
		.SLOT_W      (SLOT_W)
	) u_slots (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (slot_cmd),
		.idx       (slot_q),
		.wr_target (acc_q[SEC_W-1:0]),
		.armed     (slot_armed),
		.rd_target (slot_target)
	);

	// new time for clock requests; unchanged for anything else
	always_comb begin
		logic [HOUR_W-1:0] ph;
		logic [MIN_W-1:0]  pm, ps;
		ph = (hv_q < dcd_pkg::HOURS_PER_DAY) ? HOUR_W'(hv_q) : '0;
		pm = (mv_q < dcd_pkg::MINS_PER_HOUR) ? MIN_W'(mv_q) : '0;
		ps = (sv_q < dcd_pkg::MINS_PER_HOUR) ? MIN_W'(sv_q) : '0;
		new_sec = sec_q;
		case (req_q)
			dcd_pkg::REQ_TICK_UP: begin
				new_sec = (sec_q == dcd_pkg::DAY_LAST_SEC) ? '0 : sec_q + 1'b1;
			end
			dcd_pkg::REQ_TICK_DOWN: begin
				new_sec = (sec_q == '0) ? dcd_pkg::DAY_LAST_SEC : sec_q - 1'b1;
			end
			dcd_pkg::REQ_PRESET: begin
				new_sec = dcd_pkg::compose(ph, pm, ps);
			end
			dcd_pkg::REQ_SET_HOUR: begin
				if (hv_q < dcd_pkg::HOURS_PER_DAY)
					new_sec = dcd_pkg::compose(ph, min_q, s_q);
			end
			dcd_pkg::REQ_SET_MIN: begin
				if (mv_q < dcd_pkg::MINS_PER_HOUR)
					new_sec = dcd_pkg::compose(hour_q, pm, s_q);
			end
			dcd_pkg::REQ_SET_SEC: begin
				if (sv_q < dcd_pkg::MINS_PER_HOUR)
					new_sec = dcd_pkg::compose(hour_q, min_q, ps);
			end
			default: begin
				new_sec = sec_q;
			end
		endcase
	end

	// sequencer: next state, shared unit operands, slot commands
	always_comb begin
		state_d  = state_q;
		sub_a    = acc_q;
		sub_b    = ACC_W'(dcd_pkg::MIN_SEC);
		slot_cmd = '0;
		load_out = 1'b0;
		case (state_q)
			dcd_pkg::S_IDLE: begin
				if (accept) state_d = dcd_pkg::S_CALC;
			end
			dcd_pkg::S_CALC: begin
				if (req_q == dcd_pkg::REQ_DELAY) begin
					if (!slot_ok_q) begin
						state_d = dcd_pkg::S_DONE;
					end else if (slot_armed) begin
						slot_cmd.rd = 1'b1;
						state_d = dcd_pkg::S_TEST;
					end else begin
						state_d = dcd_pkg::S_WRAP;
					end
				end else begin
					state_d = dcd_pkg::S_HOUR;
				end
			end
			dcd_pkg::S_WRAP: begin
				sub_b = ACC_W'(dcd_pkg::DAY_SEC);
				if (!sub_ge) begin
					slot_cmd.arm = 1'b1;
					state_d = dcd_pkg::S_DONE;
				end
			end
			dcd_pkg::S_TEST: begin
				sub_a = ACC_W'(sec_q);
				sub_b = ACC_W'(slot_target);
				slot_cmd.disarm = sub_ge;
				state_d = dcd_pkg::S_DONE;
			end
			dcd_pkg::S_HOUR: begin
				sub_b = ACC_W'(dcd_pkg::HOUR_SEC);
				if (!sub_ge) state_d = dcd_pkg::S_MIN;
			end
			dcd_pkg::S_MIN: begin
				if (!sub_ge) state_d = dcd_pkg::S_DONE;
			end
			dcd_pkg::S_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d = dcd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dcd_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dcd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request latch and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= s_tuser;
			hv_q      <= s_tdata[7:0];
			mv_q      <= s_tdata[15:8];
			sv_q      <= s_tdata[23:16];
			slot_q    <= SLOT_W'(slot_in);
			slot_ok_q <= (32'(slot_in) < 32'(DELAY_SLOTS));
			len_q     <= s_tdata[44:28];
		end
		case (state_q)
			dcd_pkg::S_CALC: begin
				new_q  <= new_sec;
				hcnt_q <= '0;
				mcnt_q <= '0;
				if (req_q == dcd_pkg::REQ_DELAY) begin
					acc_q <= ACC_W'(sec_q) + ACC_W'(len_q);
				end else begin
					acc_q <= ACC_W'(new_sec);
				end
			end
			dcd_pkg::S_WRAP: begin
				if (sub_ge) acc_q <= sub_diff;
			end
			dcd_pkg::S_HOUR: begin
				if (sub_ge) begin
					acc_q  <= sub_diff;
					hcnt_q <= hcnt_q + 1'b1;
				end
			end
			dcd_pkg::S_MIN: begin
				if (sub_ge) begin
					acc_q  <= sub_diff;
					mcnt_q <= mcnt_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// time state, fired flag and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q       <= '0;
			hour_q      <= '0;
			min_q       <= '0;
			s_q         <= '0;
			fired_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (state_q == dcd_pkg::S_CALC) fired_q <= 1'b0;
			if (state_q == dcd_pkg::S_TEST) fired_q <= sub_ge;
			// commit the new time once the split is complete
			if (state_q == dcd_pkg::S_MIN && !sub_ge) begin
				sec_q  <= new_q;
				hour_q <= hcnt_q;
				min_q  <= mcnt_q;
				s_q    <= acc_q[MIN_W-1:0];
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				out_data_q  <= {1'b0, fired_q,
					dcd_pkg::units_of(s_q), dcd_pkg::tens_of(s_q),
					dcd_pkg::units_of(min_q), dcd_pkg::tens_of(min_q),
					dcd_pkg::units_of(MIN_W'(hour_q)),
					2'(dcd_pkg::tens_of(MIN_W'(hour_q))),
					s_q, min_q, hour_q, sec_q};
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
